@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property that must hold during reset too.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ sv/kcl_pkg.sv @@
package kcl_pkg;

  // Lock modes, one-hot.
  typedef enum logic [3:0] {
    MODE_CLOSED   = 4'b0001,
    MODE_ENTERING = 4'b0010,
    MODE_OPEN     = 4'b0100,
    MODE_DENIED   = 4'b1000
  } mode_t;

  // Encoded lock state as shown on the result channel.
  localparam logic [1:0] LS_CLOSED   = 2'd0;
  localparam logic [1:0] LS_ENTERING = 2'd1;
  localparam logic [1:0] LS_OPEN     = 2'd2;
  localparam logic [1:0] LS_DENIED   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DENY_TICKS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_SEC   = 3'd6;

  // Register reset values.
  localparam logic [3:0] CODE_RST_FIRST  = 4'd4;
  localparam logic [3:0] CODE_RST_SECOND = 4'd3;
  localparam logic [3:0] CODE_RST_THIRD  = 4'd2;
  localparam logic [3:0] CODE_RST_FOURTH = 4'd1;
  localparam logic [7:0] OPEN_TICKS_RST  = 8'd5;
  localparam logic [7:0] DENY_TICKS_RST  = 8'd2;
  localparam logic [7:0] TICKS_SEC_RST   = 8'd10;
  localparam logic [7:0] PRESCALE_RST    = 8'd9;

  // Keypad and time-of-day limits.
  localparam logic [7:0] KEY_ZERO = 8'd48;
  localparam logic [7:0] KEY_NINE = 8'd57;
  localparam logic [1:0] LAST_DIGIT = 2'd3;
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;

  typedef struct packed {
    logic [1:0] lock_state;
    logic       door_drive;
    logic [1:0] digits_matched;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       second_strobe;
  } res_t;

endpackage

@@ sv/keypad_code_lock_with_clock.sv @@
// Keypad code lock with a 24-hour time-of-day clock.
//
// Input channel (in_valid/in_ready): one transaction per periodic tick, carrying
// the raw keypad byte in in_key_code. Bytes '0' to '9' are digits, all others
// are ignored by the lock. Result channel (out_valid/out_ready): exactly one
// transaction per input, with lock state, door drive, matched digit count,
// time of day and a strobe that marks ticks on which the clock advanced.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (code digits
// 0..3, open ticks, deny ticks, ticks per second); write only while idle.
//
// The result of a tick is registered and on the out_ ports after the edge that
// takes it, unless the output stalls. Throughput is one tick per cycle while
// in_ready is high; a single pass of compare and increment logic updates all
// state at acceptance. A two-entry output buffer lets one more tick be taken
// while a result is stalled; in_ready drops only when both entries are full.
// Synchronous reset restores the register defaults (code 4-3-2-1, open 5,
// deny 2, ticks per second 10), closes the lock, zeroes the clock and presets
// the prescaler so the first tick after reset advances the clock.
module keypad_code_lock_with_clock (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_key_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_lock_state,
  output logic                          out_door_drive,
  output logic [1:0]                    out_digits_matched,
  output logic [4:0]                    out_hours,
  output logic [5:0]                    out_minutes,
  output logic [5:0]                    out_seconds,
  output logic                          out_second_strobe,
  input  logic                          cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import kcl_pkg::*;

  // Configuration registers
  logic [3:0] code_r [4];
  logic [7:0] open_ticks_r;
  logic [7:0] deny_ticks_r;
  logic [7:0] tps_r;

  // Block state
  mode_t      mode_r, mode_nxt;
  logic [7:0] dwell_r, dwell_nxt;
  logic [1:0] match_r, match_nxt;
  logic [7:0] pre_r, pre_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic       door_r, door_nxt;

  // Output buffer
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res_nxt;

  logic       accept;
  logic [8:0] pre_inc;
  logic       strobe;
  logic       is_digit;
  logic [3:0] digit;
  logic [8:0] dwell_inc;
  logic       digit_ok;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r[0]    <= CODE_RST_FIRST;
      code_r[1]    <= CODE_RST_SECOND;
      code_r[2]    <= CODE_RST_THIRD;
      code_r[3]    <= CODE_RST_FOURTH;
      open_ticks_r <= OPEN_TICKS_RST;
      deny_ticks_r <= DENY_TICKS_RST;
      tps_r        <= TICKS_SEC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_FIRST:  code_r[0]    <= cfg_wdata[3:0];
        REG_CODE_SECOND: code_r[1]    <= cfg_wdata[3:0];
        REG_CODE_THIRD:  code_r[2]    <= cfg_wdata[3:0];
        REG_CODE_FOURTH: code_r[3]    <= cfg_wdata[3:0];
        REG_OPEN_TICKS:  open_ticks_r <= cfg_wdata;
        REG_DENY_TICKS:  deny_ticks_r <= cfg_wdata;
        REG_TICKS_SEC:   tps_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Prescaler and time of day
  always_comb begin
    pre_inc = {1'b0, pre_r} + 9'd1;
    strobe  = pre_inc >= {1'b0, tps_r};
    pre_nxt  = strobe ? 8'd0 : pre_inc[7:0];
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    if (strobe) begin
      if (sec_r >= SEC_MAX) begin
        sec_nxt = '0;
        if (min_r >= MIN_MAX) begin
          min_nxt  = '0;
          hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
        end else begin
          min_nxt = min_r + 6'd1;
        end
      end else begin
        sec_nxt = sec_r + 6'd1;
      end
    end
  end

  // Lock sequencer
  always_comb begin
    is_digit  = (in_key_code >= KEY_ZERO) && (in_key_code <= KEY_NINE);
    digit     = 4'(in_key_code - KEY_ZERO);
    // A code digit above nine never matches a key
    digit_ok  = digit == code_r[match_r];
    dwell_inc = {1'b0, dwell_r} + 9'd1;
    mode_nxt  = mode_r;
    dwell_nxt = dwell_r;
    match_nxt = match_r;
    door_nxt  = door_r;
    unique case (mode_r)
      MODE_CLOSED, MODE_ENTERING: begin
        if (is_digit) begin
          dwell_nxt = '0;
          if (!digit_ok) begin
            mode_nxt  = MODE_DENIED;
            match_nxt = '0;
          end else if (match_r == LAST_DIGIT) begin
            mode_nxt  = MODE_OPEN;
            match_nxt = '0;
          end else begin
            mode_nxt  = MODE_ENTERING;
            match_nxt = match_r + 2'd1;
          end
        end
      end
      MODE_OPEN: begin
        door_nxt = 1'b1;
        if (dwell_inc >= {1'b0, open_ticks_r}) begin
          mode_nxt  = MODE_CLOSED;
          dwell_nxt = '0;
          door_nxt  = 1'b0;
        end else begin
          dwell_nxt = dwell_inc[7:0];
        end
      end
      MODE_DENIED: begin
        if (dwell_inc >= {1'b0, deny_ticks_r}) begin
          mode_nxt  = MODE_CLOSED;
          dwell_nxt = '0;
        end else begin
          dwell_nxt = dwell_inc[7:0];
        end
      end
      default: begin
        mode_nxt  = MODE_CLOSED;
        dwell_nxt = '0;
        match_nxt = '0;
        door_nxt  = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (mode_nxt)
      MODE_CLOSED:   res_nxt.lock_state = LS_CLOSED;
      MODE_ENTERING: res_nxt.lock_state = LS_ENTERING;
      MODE_OPEN:     res_nxt.lock_state = LS_OPEN;
      MODE_DENIED:   res_nxt.lock_state = LS_DENIED;
      default:       res_nxt.lock_state = LS_CLOSED;
    endcase
    res_nxt.door_drive     = door_nxt;
    res_nxt.digits_matched = match_nxt;
    res_nxt.hours          = hour_nxt;
    res_nxt.minutes        = min_nxt;
    res_nxt.seconds        = sec_nxt;
    res_nxt.second_strobe  = strobe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CLOSED;
      dwell_r <= '0;
      match_r <= '0;
      pre_r   <= PRESCALE_RST;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      door_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      dwell_r <= dwell_nxt;
      match_r <= match_nxt;
      pre_r   <= pre_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      door_r  <= door_nxt;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      // hold the stalled result, park the new one
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res_nxt;
      end
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lock_state     = out_r.lock_state;
  assign out_door_drive     = out_r.door_drive;
  assign out_digits_matched = out_r.digits_matched;
  assign out_hours          = out_r.hours;
  assign out_minutes        = out_r.minutes;
  assign out_seconds        = out_r.seconds;
  assign out_second_strobe  = out_r.second_strobe;

endmodule

@@ sv/kcl_checker.sv @@
`include "assert_macros.svh"

module kcl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    in_key_code,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_lock_state,
  input logic                          out_door_drive,
  input logic [1:0]                    out_digits_matched,
  input logic [4:0]                    out_hours,
  input logic [5:0]                    out_minutes,
  input logic [5:0]                    out_seconds,
  input logic                          out_second_strobe
);
  import kcl_pkg::*;

  // The door is only driven while the lock reports open.
  `ASSERT_CLK(a_door_only_open, clk, rst_n,
    out_valid && out_door_drive |-> out_lock_state == LS_OPEN)

  // Matched digits count only while a code is being entered.
  `ASSERT_CLK(a_match_only_entering, clk, rst_n,
    out_valid && out_lock_state != LS_ENTERING |-> out_digits_matched == 2'd0)

  // Time of day stays in range.
  `ASSERT_CLK(a_time_range, clk, rst_n,
    out_valid |-> out_hours < HOUR_LIMIT && out_minutes < MIN_LIMIT &&
      out_seconds < SEC_LIMIT)

  // A stalled result holds.
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_lock_state) &&
      $stable(out_door_drive) && $stable(out_digits_matched) &&
      $stable(out_hours) && $stable(out_minutes) && $stable(out_seconds) &&
      $stable(out_second_strobe))

  // A waiting input transaction holds.
  `ASSERT_CLK(a_in_hold, clk, rst_n,
    in_valid && !in_ready |=> in_valid && $stable(in_key_code))

endmodule

bind keypad_code_lock_with_clock kcl_checker u_kcl_checker (.*);
